### rtl/gppcf_pkg.sv
// Shared constants and types for the ground-plane contact force pipeline.
`timescale 1ns / 1ps
package gppcf_pkg;

	localparam int DW        = 32;                 // data word
	localparam int FB        = 16;                 // fraction bits
	localparam int MU_W      = FB + 3;             // friction coefficient width
	localparam int CFG_W     = DW - 1;             // unsigned register width
	localparam int NRM_W     = DW - 1;             // clamped normal force width
	localparam int FRIC_W    = MU_W + NRM_W - FB;  // friction magnitude width
	localparam int RAD_W     = 2 * DW;             // squared speed width
	localparam int SQ_STAGES = DW;                 // one root bit per stage
	localparam int DIV_Q     = FRIC_W;             // quotient bits, one per stage
	localparam int DIV_D     = DW;                 // divisor width
	localparam int DIV_N     = DIV_Q + DIV_D;      // dividend width

	localparam logic [CFG_W-1:0] LOCK_RESET = CFG_W'(6554);

	typedef enum logic [1:0] {
		REG_PLANE_HEIGHT = 2'd0,
		REG_LOCK_SPEED   = 2'd1,
		REG_STIFFNESS    = 2'd2,
		REG_DAMPING      = 2'd3
	} cfg_reg_t;

	// sideband carried alongside the square root
	typedef struct packed {
		logic              contact;
		logic [FRIC_W-1:0] fric;
		logic [NRM_W-1:0]  normal;
		logic [DW-1:0]     ax;
		logic [DW-1:0]     az;
		logic              posx;
		logic              posz;
	} fric_side_t;

	// sideband carried alongside the locking-speed divide
	typedef struct packed {
		logic             contact;
		logic [NRM_W-1:0] normal;
		logic [DW-1:0]    ax;
		logic [DW-1:0]    az;
		logic             posx;
		logic             posz;
		logic [DW-1:0]    speed;
	} lock_side_t;

	// sideband carried alongside the force divides
	typedef struct packed {
		logic             contact;
		logic [NRM_W-1:0] normal;
		logic             posx;
		logic             posz;
	} force_side_t;

endpackage

### rtl/gppcf_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module gppcf_sqrt import gppcf_pkg::*; (
	input  logic             clk,
	input  logic [RAD_W-1:0] rad,
	output logic [DW-1:0]    root
);

	logic [DW+1:0]    rem_q  [SQ_STAGES];
	logic [DW-1:0]    root_q [SQ_STAGES];
	logic [RAD_W-1:0] rad_q  [SQ_STAGES];

	logic [DW+1:0]    rem_in  [SQ_STAGES];
	logic [DW-1:0]    root_in [SQ_STAGES];
	logic [RAD_W-1:0] rad_in  [SQ_STAGES];
	logic [DW+1:0]    rem_nx  [SQ_STAGES];
	logic [DW-1:0]    root_nx [SQ_STAGES];

	always_comb begin
		rem_in[0]  = '0;
		root_in[0] = '0;
		rad_in[0]  = rad;
		for (int k = 1; k < SQ_STAGES; k++) begin
			rem_in[k]  = rem_q[k-1];
			root_in[k] = root_q[k-1];
			rad_in[k]  = rad_q[k-1];
		end
	end

	always_comb begin
		logic [DW+3:0] r2;
		logic [DW+3:0] trial;
		for (int k = 0; k < SQ_STAGES; k++) begin
			r2    = {rem_in[k], rad_in[k][RAD_W-1 -: 2]};
			trial = {2'b00, root_in[k], 2'b01};
			if (r2 >= trial) begin
				rem_nx[k]  = (DW+2)'(r2 - trial);
				root_nx[k] = {root_in[k][DW-2:0], 1'b1};
			end else begin
				rem_nx[k]  = (DW+2)'(r2);
				root_nx[k] = {root_in[k][DW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < SQ_STAGES; k++) begin
			rem_q[k]  <= rem_nx[k];
			root_q[k] <= root_nx[k];
			rad_q[k]  <= {rad_in[k][RAD_W-3:0], 2'b00};
		end
	end

	assign root = root_q[SQ_STAGES-1];

endmodule

### rtl/gppcf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module gppcf_div import gppcf_pkg::*; (
	input  logic             clk,
	input  logic [DIV_N-1:0] num,
	input  logic [DIV_D-1:0] den,
	output logic [DIV_Q-1:0] quo
);

	// quotient must fit DIV_Q bits: num < den * 2^DIV_Q
	logic [DIV_D-1:0] rem_q  [DIV_Q];
	logic [DIV_Q-1:0] word_q [DIV_Q];
	logic [DIV_D-1:0] den_q  [DIV_Q];

	logic [DIV_D-1:0] rem_in  [DIV_Q];
	logic [DIV_Q-1:0] word_in [DIV_Q];
	logic [DIV_D-1:0] den_in  [DIV_Q];
	logic [DIV_D-1:0] rem_nx  [DIV_Q];
	logic [DIV_Q-1:0] word_nx [DIV_Q];

	always_comb begin
		rem_in[0]  = num[DIV_N-1 -: DIV_D];
		word_in[0] = num[DIV_Q-1:0];
		den_in[0]  = den;
		for (int k = 1; k < DIV_Q; k++) begin
			rem_in[k]  = rem_q[k-1];
			word_in[k] = word_q[k-1];
			den_in[k]  = den_q[k-1];
		end
	end

	// shift the next dividend bit in, the quotient bit out at the bottom
	always_comb begin
		logic [DIV_D:0] t;
		logic           ge;
		for (int k = 0; k < DIV_Q; k++) begin
			t  = {rem_in[k], word_in[k][DIV_Q-1]};
			ge = (t >= {1'b0, den_in[k]});
			rem_nx[k]  = ge ? DIV_D'(t - {1'b0, den_in[k]}) : DIV_D'(t);
			word_nx[k] = {word_in[k][DIV_Q-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_Q; k++) begin
			rem_q[k]  <= rem_nx[k];
			word_q[k] <= word_nx[k];
			den_q[k]  <= den_in[k];
		end
	end

	assign quo = word_q[DIV_Q-1];

endmodule

### rtl/ground_plane_penalty_contact_force.sv
// Ground-plane penalty contact force: spring-damper normal, Coulomb friction.
// Each start that is taken yields one result, strobed on done.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Latency is set by the 32-stage square root and two 34-stage dividers in series.
// Reset clears the valid bits and loads the register reset values.
`timescale 1ns / 1ps
module ground_plane_penalty_contact_force import gppcf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [DW-1:0]     cfg_data,
	input  logic              start,
	output logic              busy,
	input  logic signed [DW-1:0] height,
	input  logic signed [DW-1:0] vel_x,
	input  logic signed [DW-1:0] vel_y,
	input  logic signed [DW-1:0] vel_z,
	input  logic [MU_W-1:0]   friction_coeff,
	output logic              done,
	output logic              in_contact,
	output logic signed [DW-1:0] force_x,
	output logic signed [DW-1:0] force_y,
	output logic signed [DW-1:0] force_z
);

	localparam logic [NRM_W-1:0] NRM_MAX = '1;

	logic [DW-1:0]    plane_height_q;
	logic [CFG_W-1:0] locking_speed_q;
	logic [CFG_W-1:0] spring_stiffness_q;
	logic [CFG_W-1:0] damping_coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_height_q     <= '0;
			locking_speed_q    <= LOCK_RESET;
			spring_stiffness_q <= '0;
			damping_coeff_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PLANE_HEIGHT: plane_height_q     <= cfg_data;
				REG_LOCK_SPEED:   locking_speed_q    <= cfg_data[CFG_W-1:0];
				REG_STIFFNESS:    spring_stiffness_q <= cfg_data[CFG_W-1:0];
				REG_DAMPING:      damping_coeff_q    <= cfg_data[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// stage 1: depth, magnitudes and signs
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic            contact_s1;
	logic [DW-1:0]   depth_s1, vymag_s1, ax_s1, az_s1;
	logic            vyneg_s1, posx_s1, posz_s1;
	logic [MU_W-1:0] mu_s1;
	logic [DW:0]     diff;

	assign diff = {plane_height_q[DW-1], plane_height_q} - {height[DW-1], height};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		contact_s1 <= !diff[DW];
		depth_s1   <= diff[DW-1:0];
		vyneg_s1   <= vel_y[DW-1];
		vymag_s1   <= vel_y[DW-1] ? DW'(-vel_y) : vel_y;
		ax_s1      <= vel_x[DW-1] ? DW'(-vel_x) : vel_x;
		az_s1      <= vel_z[DW-1] ? DW'(-vel_z) : vel_z;
		posx_s1    <= !vel_x[DW-1] && (vel_x != '0);
		posz_s1    <= !vel_z[DW-1] && (vel_z != '0);
		mu_s1      <= friction_coeff;
	end

	// stage 2: products
	logic [CFG_W+DW-1:0] spring_prod_s2, damp_prod_s2;
	logic [RAD_W-1:0]    sqx_s2, sqz_s2;
	logic                contact_s2, vyneg_s2, posx_s2, posz_s2;
	logic [DW-1:0]       ax_s2, az_s2;
	logic [MU_W-1:0]     mu_s2;

	always_ff @(posedge clk) begin
		spring_prod_s2 <= (CFG_W+DW)'(spring_stiffness_q) * (CFG_W+DW)'(depth_s1);
		damp_prod_s2   <= (CFG_W+DW)'(damping_coeff_q) * (CFG_W+DW)'(vymag_s1);
		sqx_s2         <= RAD_W'(ax_s1) * RAD_W'(ax_s1);
		sqz_s2         <= RAD_W'(az_s1) * RAD_W'(az_s1);
		contact_s2     <= contact_s1;
		vyneg_s2       <= vyneg_s1;
		posx_s2        <= posx_s1;
		posz_s2        <= posz_s1;
		ax_s2          <= ax_s1;
		az_s2          <= az_s1;
		mu_s2          <= mu_s1;
	end

	// stage 3: normal force, clamped; squared speed
	localparam int SPR_W = CFG_W + DW - FB;
	logic [SPR_W-1:0] spring, dfloor, dceil;
	logic [SPR_W:0]   nsum;
	logic [NRM_W-1:0] normal;

	always_comb begin
		spring = spring_prod_s2[CFG_W+DW-1:FB];
		dfloor = SPR_W'(damp_prod_s2[CFG_W+DW-1:FB]);
		dceil  = SPR_W'((damp_prod_s2 + (CFG_W+DW)'((1 << FB) - 1)) >> FB);
		if (vyneg_s2)
			nsum = (SPR_W+1)'(spring) + (SPR_W+1)'(dceil);
		else if (spring > dfloor)
			nsum = (SPR_W+1)'(spring - dfloor);
		else
			nsum = '0;
		normal = (nsum > (SPR_W+1)'(NRM_MAX)) ? NRM_MAX : nsum[NRM_W-1:0];
	end

	logic [NRM_W-1:0] normal_s3;
	logic [RAD_W-1:0] sumsq_s3;
	logic             contact_s3, posx_s3, posz_s3;
	logic [DW-1:0]    ax_s3, az_s3;
	logic [MU_W-1:0]  mu_s3;

	always_ff @(posedge clk) begin
		normal_s3  <= normal;
		sumsq_s3   <= sqx_s2 + sqz_s2;
		contact_s3 <= contact_s2;
		posx_s3    <= posx_s2;
		posz_s3    <= posz_s2;
		ax_s3      <= ax_s2;
		az_s3      <= az_s2;
		mu_s3      <= mu_s2;
	end

	logic [DW-1:0] speed;
	gppcf_sqrt u_sqrt (
		.clk  (clk),
		.rad  (sumsq_s3),
		.root (speed)
	);

	// stage 4: friction magnitude
	logic [MU_W+NRM_W-1:0] fric_prod;
	fric_side_t            side_s4;

	assign fric_prod = (MU_W+NRM_W)'(mu_s3) * (MU_W+NRM_W)'(normal_s3);

	always_ff @(posedge clk) begin
		side_s4.contact <= contact_s3;
		side_s4.fric    <= fric_prod[MU_W+NRM_W-1:FB];
		side_s4.normal  <= normal_s3;
		side_s4.ax      <= ax_s3;
		side_s4.az      <= az_s3;
		side_s4.posx    <= posx_s3;
		side_s4.posz    <= posz_s3;
	end

	// hold the sideband until the root comes out
	fric_side_t             fric_side_q [SQ_STAGES-1];
	logic [SQ_STAGES-2:0]   fric_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fric_vld_q <= '0;
		else
			fric_vld_q <= {fric_vld_q[SQ_STAGES-3:0], valid_s4};
	end

	always_ff @(posedge clk) begin
		fric_side_q[0] <= side_s4;
		for (int k = 1; k < SQ_STAGES-1; k++)
			fric_side_q[k] <= fric_side_q[k-1];
	end

	// stage 5: scale below the locking speed
	fric_side_t       fs;
	logic             scale;
	logic [DIV_N-1:0] lock_n_s5;
	logic [DIV_D-1:0] lock_d_s5;
	lock_side_t       side_s5;

	assign fs    = fric_side_q[SQ_STAGES-2];
	assign scale = (speed != '0) && (speed < DW'(locking_speed_q));

	always_ff @(posedge clk) begin
		lock_n_s5      <= scale ? DIV_N'(fs.fric) * DIV_N'(speed) : DIV_N'(fs.fric);
		lock_d_s5      <= scale ? DIV_D'(locking_speed_q) : DIV_D'(1);
		side_s5.contact <= fs.contact;
		side_s5.normal  <= fs.normal;
		side_s5.ax      <= fs.ax;
		side_s5.az      <= fs.az;
		side_s5.posx    <= fs.posx;
		side_s5.posz    <= fs.posz;
		side_s5.speed   <= speed;
	end

	logic [DIV_Q-1:0] fric_lock;
	gppcf_div u_div_lock (
		.clk (clk),
		.num (lock_n_s5),
		.den (lock_d_s5),
		.quo (fric_lock)
	);

	lock_side_t       lock_side_q [DIV_Q];
	logic [DIV_Q-1:0] lock_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5   <= 1'b0;
			lock_vld_q <= '0;
		end else begin
			valid_s5   <= fric_vld_q[SQ_STAGES-2];
			lock_vld_q <= {lock_vld_q[DIV_Q-2:0], valid_s5};
		end
	end

	always_ff @(posedge clk) begin
		lock_side_q[0] <= side_s5;
		for (int k = 1; k < DIV_Q; k++)
			lock_side_q[k] <= lock_side_q[k-1];
	end

	// stage 6: split friction over x and z
	lock_side_t       ls;
	logic             still;
	logic [DIV_N-1:0] nx_s6, nz_s6;
	logic [DIV_D-1:0] d_s6;
	force_side_t      side_s6;

	assign ls    = lock_side_q[DIV_Q-1];
	assign still = (ls.speed == '0);

	always_ff @(posedge clk) begin
		nx_s6 <= still ? '0 : DIV_N'(fric_lock) * DIV_N'(ls.ax);
		nz_s6 <= still ? '0 : DIV_N'(fric_lock) * DIV_N'(ls.az);
		d_s6  <= still ? DIV_D'(1) : ls.speed;
		side_s6.contact <= ls.contact;
		side_s6.normal  <= ls.normal;
		side_s6.posx    <= ls.posx;
		side_s6.posz    <= ls.posz;
	end

	logic [DIV_Q-1:0] mag_x, mag_z;
	gppcf_div u_div_x (
		.clk (clk),
		.num (nx_s6),
		.den (d_s6),
		.quo (mag_x)
	);
	gppcf_div u_div_z (
		.clk (clk),
		.num (nz_s6),
		.den (d_s6),
		.quo (mag_z)
	);

	force_side_t      force_side_q [DIV_Q];
	logic [DIV_Q-1:0] force_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6    <= 1'b0;
			force_vld_q <= '0;
			valid_s7    <= 1'b0;
		end else begin
			valid_s6    <= lock_vld_q[DIV_Q-1];
			force_vld_q <= {force_vld_q[DIV_Q-2:0], valid_s6};
			valid_s7    <= force_vld_q[DIV_Q-1];
		end
	end

	always_ff @(posedge clk) begin
		force_side_q[0] <= side_s6;
		for (int k = 1; k < DIV_Q; k++)
			force_side_q[k] <= force_side_q[k-1];
	end

	// stage 7: sign and saturate
	function automatic logic [DW-1:0] sat_out(input logic [DIV_Q-1:0] m, input logic neg);
		logic [DIV_Q-1:0] lim;
		begin
			if (neg) begin
				lim = (m > (DIV_Q'(1) << (DW-1))) ? (DIV_Q'(1) << (DW-1)) : m;
				sat_out = DW'(-lim);
			end else begin
				lim = (m > DIV_Q'(NRM_MAX)) ? DIV_Q'(NRM_MAX) : m;
				sat_out = lim[DW-1:0];
			end
		end
	endfunction

	force_side_t   fo;
	logic          contact_s7;
	logic [DW-1:0] fx_s7, fy_s7, fz_s7;

	assign fo = force_side_q[DIV_Q-1];

	always_ff @(posedge clk) begin
		contact_s7 <= fo.contact;
		fx_s7 <= fo.contact ? sat_out(mag_x, fo.posx) : '0;
		fy_s7 <= fo.contact ? DW'(fo.normal) : '0;
		fz_s7 <= fo.contact ? sat_out(mag_z, fo.posz) : '0;
	end

	assign done       = valid_s7;
	assign in_contact = contact_s7;
	assign force_x    = fx_s7;
	assign force_y    = fy_s7;
	assign force_z    = fz_s7;

endmodule
